// ===== rtl/nfes_pkg.sv =====
// Package for the Nesterov force embedding step unit.
// Request and result structs, operation and link codes, saturation helper.
// No dependencies.
package nfes_pkg;

    localparam int DEFAULT_MAX_PARTICLES = 1024;
    localparam int DEFAULT_FRAC_BITS     = 16;

    localparam logic [1:0] OP_LOAD    = 2'd0;
    localparam logic [1:0] OP_EDGE    = 2'd1;
    localparam logic [1:0] OP_ADVANCE = 2'd2;

    localparam logic [1:0] LINK_NEAR    = 2'd0;
    localparam logic [1:0] LINK_REVERSE = 2'd1;
    localparam logic [1:0] LINK_RANDOM  = 2'd2;

    localparam logic [1:0] CFG_MOMENTUM_GAIN = 2'd0;
    localparam logic [1:0] CFG_FORCE_GAIN    = 2'd1;
    localparam logic [1:0] CFG_RANDOM_WEIGHT = 2'd2;

    typedef struct packed {
        logic [1:0]         op;
        logic [9:0]         index_a;
        logic [9:0]         index_b;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic               alive;
        logic [30:0]        target_distance;
        logic [1:0]         link_type;
    } nfes_in_t;

    typedef struct packed {
        logic [9:0]         particle;
        logic signed [31:0] out_pos_x;
        logic signed [31:0] out_pos_y;
        logic signed [31:0] out_vel_x;
        logic signed [31:0] out_vel_y;
        logic signed [31:0] energy;
    } nfes_out_t;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] r;
        if (v > 66'sh0_7FFF_FFFF)
            r = 32'sh7FFF_FFFF;
        else if (v < -66'sh0_8000_0000)
            r = 32'sh8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

// ===== rtl/nesterov_force_embedding_step_unit.sv =====
// Nesterov force embedding step unit: particle table in two synchronous memories.
// One shared 32x32 multiplier, bit-pair square root and restoring divider.
// Depends on nfes_pkg.
//
//  channel  | signals                          | moves
//  ---------+----------------------------------+-------------------------
//  item     | item_valid, item_ready, item     | one request (nfes_in_t)
//  result   | result_valid, result_ready, result | one result (nfes_out_t)
//  config   | cfg_we, cfg_index, cfg_data      | one register write
//
// An edge request uses the multiplier, 32 square root steps and 33 + FRAC_BITS divider
// steps; random links add a weighting pass on the multiplier.
// After reset a clearing pass over all MAX_PARTICLES entries zeroes force and alive bits;
// item_ready stays low meanwhile. One request is worked at a time; a finished
// result waits in the output register and the next request is taken meanwhile.
module nesterov_force_embedding_step_unit #(
    parameter int MAX_PARTICLES = nfes_pkg::DEFAULT_MAX_PARTICLES,
    parameter int FRAC_BITS     = nfes_pkg::DEFAULT_FRAC_BITS
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    input  nfes_pkg::nfes_in_t  item,
    output logic                result_valid,
    input  logic                result_ready,
    output nfes_pkg::nfes_out_t result,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [31:0]         cfg_data
);
    import nfes_pkg::*;

    localparam int AW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
    localparam int QW = 33 + FRAC_BITS;

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_CLEAR = 5'd1;
    localparam logic [4:0] S_DISP  = 5'd2;
    localparam logic [4:0] S_LOAD  = 5'd3;
    localparam logic [4:0] S_RDA   = 5'd4;
    localparam logic [4:0] S_RDB   = 5'd5;
    localparam logic [4:0] S_LA    = 5'd6;
    localparam logic [4:0] S_SQX   = 5'd7;
    localparam logic [4:0] S_SQY   = 5'd8;
    localparam logic [4:0] S_SQS   = 5'd9;
    localparam logic [4:0] S_SQRT  = 5'd10;
    localparam logic [4:0] S_DIVP  = 5'd11;
    localparam logic [4:0] S_DIV   = 5'd12;
    localparam logic [4:0] S_RATIO = 5'd13;
    localparam logic [4:0] S_PX    = 5'd14;
    localparam logic [4:0] S_PY    = 5'd15;
    localparam logic [4:0] S_PW    = 5'd16;
    localparam logic [4:0] S_RW1   = 5'd17;
    localparam logic [4:0] S_RW2   = 5'd18;
    localparam logic [4:0] S_RW3   = 5'd19;
    localparam logic [4:0] S_FA    = 5'd20;
    localparam logic [4:0] S_FB    = 5'd21;
    localparam logic [4:0] S_AV0   = 5'd22;
    localparam logic [4:0] S_AV1   = 5'd23;
    localparam logic [4:0] S_AV2   = 5'd24;
    localparam logic [4:0] S_AV3   = 5'd25;
    localparam logic [4:0] S_AV4   = 5'd26;
    localparam logic [4:0] S_AV5   = 5'd27;
    localparam logic [4:0] S_DONE  = 5'd28;

    localparam logic [1:0] MODE_EDGE   = 2'd0;
    localparam logic [1:0] MODE_ADV    = 2'd1;
    localparam logic [1:0] MODE_REPORT = 2'd2;

    // memories: {pos_x, pos_y, vel_x, vel_y} and {alive, force_x, force_y}
    logic [127:0] pv_mem [MAX_PARTICLES];
    logic [64:0]  fa_mem [MAX_PARTICLES];
    logic [127:0] pv_rd;
    logic [64:0]  fa_rd;

    logic [AW-1:0] rd_addr, wr_addr;
    logic          pv_we, fa_we;
    logic [127:0]  pv_wdata;
    logic [64:0]   fa_wdata;

    logic [4:0]    state_reg;
    logic [1:0]    mode_reg;
    logic [AW-1:0] clr_cnt_reg;
    logic [6:0]    step_reg;
    nfes_in_t      in_reg;
    logic          out_valid_reg;
    nfes_out_t     out_reg;

    logic signed [31:0] mgain_reg, fgain_reg, rweight_reg;
    logic signed [31:0] energy_reg, ratio_reg;

    logic [127:0]       a_pv_reg;
    logic [64:0]        a_fa_reg, b_fa_reg;
    logic signed [31:0] dx_reg, dy_reg, px_reg, py_reg;
    logic signed [31:0] nfx_reg, nfy_reg, nvx_reg;
    logic [63:0]        sq_reg, rem_sq_reg, res_reg, bit_reg;
    logic signed [63:0] acc_reg, prod_reg;
    logic [32:0]        r_reg;
    logic [33:0]        rem_reg;
    logic [QW-1:0]      dvd_reg;
    logic               neg_reg;

    logic signed [31:0] mul_x, mul_y;
    logic [AW-1:0]      addr_a, addr_b;
    logic               a_ok, b_ok;

    assign addr_a = AW'(in_reg.index_a);
    assign addr_b = AW'(in_reg.index_b);
    assign a_ok   = 32'(in_reg.index_a) < MAX_PARTICLES;
    assign b_ok   = 32'(in_reg.index_b) < MAX_PARTICLES;

    assign item_ready   = (state_reg == S_IDLE);
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    always_ff @(posedge clk)
    begin
        if (pv_we)
            pv_mem[wr_addr] <= pv_wdata;
        if (fa_we)
            fa_mem[wr_addr] <= fa_wdata;
        pv_rd <= pv_mem[rd_addr];
        fa_rd <= fa_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= 64'(mul_x) * 64'(mul_y);
    end

    // pipeline arithmetic from the read data
    logic signed [31:0] la_ax, la_ay, la_bx, la_by, mq;
    logic signed [65:0] adv_sum;
    logic [63:0]        sq_try;
    logic [33:0]        div_t;
    logic [32:0]        abs_num, d_val;
    logic signed [31:0] fb_x, fb_y, new_px, new_py;
    logic signed [31:0] ratio_val;

    always_comb
    begin
        la_ax   = sat32(66'($signed(a_pv_reg[127:96])) + 66'($signed(a_pv_reg[63:32])));
        la_ay   = sat32(66'($signed(a_pv_reg[95:64])) + 66'($signed(a_pv_reg[31:0])));
        la_bx   = sat32(66'($signed(pv_rd[127:96])) + 66'($signed(pv_rd[63:32])));
        la_by   = sat32(66'($signed(pv_rd[95:64])) + 66'($signed(pv_rd[31:0])));
        mq      = sat32(66'(prod_reg >>> FRAC_BITS));
        adv_sum = (66'(acc_reg) + 66'(prod_reg)) >>> FRAC_BITS;
        sq_try  = res_reg + bit_reg;
        div_t   = {rem_reg[32:0], dvd_reg[QW-1]};
        d_val   = (in_reg.link_type == LINK_NEAR || in_reg.link_type == LINK_REVERSE)
                  ? 33'd0 : 33'(in_reg.target_distance);
        abs_num = (res_reg[32:0] + 33'd1 > d_val) ? (res_reg[32:0] + 33'd1 - d_val)
                                                 : (d_val - res_reg[32:0] - 33'd1);
        fb_x    = (addr_a == addr_b) ? nfx_reg : $signed(b_fa_reg[63:32]);
        fb_y    = (addr_a == addr_b) ? nfy_reg : $signed(b_fa_reg[31:0]);
        new_px  = sat32(66'($signed(a_pv_reg[127:96])) + 66'(nvx_reg));
        new_py  = sat32(66'($signed(a_pv_reg[95:64])) + 66'(sat32(adv_sum)));
        if (!neg_reg)
            ratio_val = (dvd_reg > QW'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF
                                                       : $signed(dvd_reg[31:0]);
        else
            ratio_val = (dvd_reg >= QW'(32'h8000_0000)) ? 32'sh8000_0000
                                                        : -$signed(dvd_reg[31:0]);
    end

    always_comb
    begin
        mul_x = dx_reg;
        mul_y = dx_reg;
        case (state_reg)
            S_SQY:   begin mul_x = dy_reg;    mul_y = dy_reg;    end
            S_PX:    begin mul_x = dx_reg;    mul_y = ratio_reg; end
            S_PY:    begin mul_x = dy_reg;    mul_y = ratio_reg; end
            S_RW1:   begin mul_x = px_reg;    mul_y = rweight_reg; end
            S_RW2:   begin mul_x = py_reg;    mul_y = rweight_reg; end
            S_AV0:   begin mul_x = mgain_reg; mul_y = $signed(a_pv_reg[63:32]); end
            S_AV1:   begin mul_x = fgain_reg; mul_y = $signed(a_fa_reg[63:32]); end
            S_AV2:   begin mul_x = mgain_reg; mul_y = $signed(a_pv_reg[31:0]); end
            S_AV3, S_AV4:
                     begin mul_x = fgain_reg; mul_y = $signed(a_fa_reg[31:0]); end
            default: begin mul_x = dx_reg;    mul_y = dx_reg;    end
        endcase
    end

    always_comb
    begin
        rd_addr  = (state_reg == S_RDB) ? addr_b : addr_a;
        wr_addr  = addr_a;
        pv_we    = 1'b0;
        fa_we    = 1'b0;
        pv_wdata = a_pv_reg;
        fa_wdata = '0;
        case (state_reg)
            S_CLEAR:
            begin
                wr_addr = clr_cnt_reg;
                fa_we   = 1'b1;
            end
            S_LOAD:
            begin
                pv_we    = a_ok;
                fa_we    = a_ok;
                pv_wdata = {in_reg.pos_x, in_reg.pos_y, in_reg.vel_x, in_reg.vel_y};
                fa_wdata = {in_reg.alive, 64'd0};
            end
            S_FA:
            begin
                fa_we    = 1'b1;
                fa_wdata = {a_fa_reg[64],
                            sat32(66'($signed(a_fa_reg[63:32])) + 66'(px_reg)),
                            sat32(66'($signed(a_fa_reg[31:0])) + 66'(py_reg))};
            end
            S_FB:
            begin
                wr_addr  = addr_b;
                fa_we    = 1'b1;
                fa_wdata = {b_fa_reg[64], sat32(66'(fb_x) - 66'(px_reg)),
                            sat32(66'(fb_y) - 66'(py_reg))};
            end
            S_AV5:
            begin
                pv_we    = a_fa_reg[64];
                fa_we    = 1'b1;
                pv_wdata = {new_px, new_py, nvx_reg, sat32(adv_sum)};
                fa_wdata = {a_fa_reg[64], 64'd0};
            end
            default:
            begin
                fa_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mgain_reg   <= 32'(1) <<< FRAC_BITS;
            fgain_reg   <= 32'(1) <<< FRAC_BITS;
            rweight_reg <= 32'(1) <<< FRAC_BITS;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MOMENTUM_GAIN: mgain_reg   <= cfg_data;
                CFG_FORCE_GAIN:    fgain_reg   <= cfg_data;
                CFG_RANDOM_WEIGHT: rweight_reg <= cfg_data;
                default:           mgain_reg   <= mgain_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
            energy_reg    <= '0;
        end
        else
        begin
            case (state_reg)
                S_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + AW'(1);
                    if (32'(clr_cnt_reg) == MAX_PARTICLES - 1)
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                    if (item_valid)
                        state_reg <= S_DISP;
                S_DISP:
                begin
                    if (in_reg.op == OP_LOAD)
                        state_reg <= S_LOAD;
                    else if (!a_ok)
                        state_reg <= S_DONE;
                    else
                        state_reg <= S_RDA;
                    if (in_reg.op == OP_EDGE && b_ok)
                        mode_reg <= MODE_EDGE;
                    else if (in_reg.op == OP_ADVANCE)
                        mode_reg <= MODE_ADV;
                    else
                        mode_reg <= MODE_REPORT;
                end
                S_LOAD:  state_reg <= S_DONE;
                S_RDA:   state_reg <= S_RDB;
                S_RDB:
                    case (mode_reg)
                        MODE_EDGE: state_reg <= S_LA;
                        MODE_ADV:  state_reg <= S_AV0;
                        default:   state_reg <= S_DONE;
                    endcase
                S_LA:    state_reg <= S_SQX;
                S_SQX:   state_reg <= S_SQY;
                S_SQY:   state_reg <= S_SQS;
                S_SQS:   state_reg <= S_SQRT;
                S_SQRT:
                begin
                    step_reg <= step_reg + 7'd1;
                    if (step_reg == 7'd31)
                        state_reg <= S_DIVP;
                end
                S_DIVP:  state_reg <= S_DIV;
                S_DIV:
                begin
                    step_reg <= step_reg + 7'd1;
                    if (step_reg == 7'(QW - 1))
                        state_reg <= S_RATIO;
                end
                S_RATIO:
                begin
                    energy_reg <= ratio_val;
                    state_reg  <= S_PX;
                end
                S_PX:    state_reg <= S_PY;
                S_PY:    state_reg <= S_PW;
                S_PW:    state_reg <= (in_reg.link_type == LINK_RANDOM) ? S_RW1 : S_FA;
                S_RW1:   state_reg <= S_RW2;
                S_RW2:   state_reg <= S_RW3;
                S_RW3:   state_reg <= S_FA;
                S_FA:    state_reg <= S_FB;
                S_FB:    state_reg <= S_DONE;
                S_AV0:   state_reg <= S_AV1;
                S_AV1:   state_reg <= S_AV2;
                S_AV2:   state_reg <= S_AV3;
                S_AV3:   state_reg <= S_AV4;
                S_AV4:   state_reg <= S_AV5;
                S_AV5:   state_reg <= S_DONE;
                S_DONE:
                    if (!out_valid_reg || result_ready)
                        state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
            if (state_reg == S_SQS || state_reg == S_DIVP)
                step_reg <= '0;
            if (state_reg == S_DONE && (!out_valid_reg || result_ready))
                out_valid_reg <= 1'b1;
            else if (result_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // datapath registers, no reset
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
                if (item_valid)
                    in_reg <= item;
            S_LOAD:
                a_pv_reg <= {in_reg.pos_x, in_reg.pos_y, in_reg.vel_x, in_reg.vel_y};
            S_RDB:
            begin
                a_pv_reg <= pv_rd;
                a_fa_reg <= fa_rd;
            end
            S_LA:
            begin
                b_fa_reg <= fa_rd;
                dx_reg   <= sat32(66'(la_ax) - 66'(la_bx));
                dy_reg   <= sat32(66'(la_ay) - 66'(la_by));
            end
            S_SQY:
                sq_reg <= prod_reg;
            S_SQS:
            begin
                rem_sq_reg <= sq_reg + prod_reg;
                res_reg    <= '0;
                bit_reg    <= 64'd1 << 62;
            end
            S_SQRT:
            begin
                if (rem_sq_reg >= sq_try)
                begin
                    rem_sq_reg <= rem_sq_reg - sq_try;
                    res_reg    <= (res_reg >> 1) + bit_reg;
                end
                else
                    res_reg <= res_reg >> 1;
                bit_reg <= bit_reg >> 2;
            end
            S_DIVP:
            begin
                r_reg   <= res_reg[32:0] + 33'd1;
                neg_reg <= (res_reg[32:0] + 33'd1 > d_val);
                dvd_reg <= QW'(abs_num) << FRAC_BITS;
                rem_reg <= '0;
            end
            S_DIV:
                if (div_t >= {1'b0, r_reg})
                begin
                    rem_reg <= div_t - {1'b0, r_reg};
                    dvd_reg <= {dvd_reg[QW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= div_t;
                    dvd_reg <= {dvd_reg[QW-2:0], 1'b0};
                end
            S_RATIO: ratio_reg <= ratio_val;
            S_PY:    px_reg <= mq;
            S_PW:    py_reg <= mq;
            S_RW2:   px_reg <= mq;
            S_RW3:   py_reg <= mq;
            S_FA:
            begin
                nfx_reg <= sat32(66'($signed(a_fa_reg[63:32])) + 66'(px_reg));
                nfy_reg <= sat32(66'($signed(a_fa_reg[31:0])) + 66'(py_reg));
            end
            S_AV1:   acc_reg <= prod_reg;
            S_AV2:   nvx_reg <= sat32(adv_sum);
            S_AV3:   acc_reg <= prod_reg;
            S_AV5:
                if (a_fa_reg[64])
                    a_pv_reg <= {new_px, new_py, nvx_reg, sat32(adv_sum)};
            S_DONE:
                if (!out_valid_reg || result_ready)
                begin
                    out_reg.particle  <= in_reg.index_a;
                    out_reg.out_pos_x <= a_ok ? $signed(a_pv_reg[127:96]) : 32'sd0;
                    out_reg.out_pos_y <= a_ok ? $signed(a_pv_reg[95:64]) : 32'sd0;
                    out_reg.out_vel_x <= a_ok ? $signed(a_pv_reg[63:32]) : 32'sd0;
                    out_reg.out_vel_y <= a_ok ? $signed(a_pv_reg[31:0]) : 32'sd0;
                    out_reg.energy    <= energy_reg;
                end
            default:
                neg_reg <= neg_reg;
        endcase
    end

    a_clear_blocks_requests: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> !item_ready)
        else $error("request taken during clearing pass");

    a_energy_only_on_ratio: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_RATIO) |=> $stable(energy_reg))
        else $error("energy changed outside ratio step");

    a_done_holds_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && out_valid_reg && !result_ready) |=> (state_reg == S_DONE))
        else $error("result overwritten while stalled");

    a_pv_write_states: assert property (@(posedge clk) disable iff (!rst_n)
        pv_we |-> (state_reg == S_LOAD || state_reg == S_AV5))
        else $error("position store written outside load or advance");

endmodule
